FILE: sv/nalx_pkg.sv
`timescale 1ns / 1ps

package nalx_pkg;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [7:0] BYTE_EPB  = 8'h03;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       nal_end;
	} result_t;

	// results of one input byte, in order: zeros, then the byte, then the end marker
	typedef struct packed {
		logic [1:0] zeros;
		logic       has_byte;
		logic [7:0] data;
		logic       has_end;
	} burst_t;

endpackage

FILE: sv/nalx_step.sv
`timescale 1ns / 1ps

module nalx_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  nalx_pkg::item_t  item,
	output nalx_pkg::burst_t burst
);
	import nalx_pkg::*;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_INSIDE = 2'd1,
		PH_DONE   = 2'd2,
		PH_SPARE  = 2'd3
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [1:0] zero_run_q, zero_run_n;

	always_comb begin
		phase_n        = phase_q;
		zero_run_n     = zero_run_q;
		burst.zeros    = 2'd0;
		burst.has_byte = 1'b0;
		burst.data     = item.data_byte;
		burst.has_end  = 1'b0;
		case (phase_q)
			PH_SEARCH: begin
				if (item.data_byte == BYTE_ZERO) begin
					if (zero_run_q != 2'd2) begin
						zero_run_n = zero_run_q + 2'd1;
					end
				end else if (item.data_byte == BYTE_ONE && zero_run_q == 2'd2) begin
					phase_n    = PH_INSIDE;
					zero_run_n = 2'd0;
				end else begin
					zero_run_n = 2'd0;
				end
			end
			PH_INSIDE: begin
				if (item.data_byte == BYTE_ZERO) begin
					if (zero_run_q != 2'd2) begin
						zero_run_n = zero_run_q + 2'd1;
					end else begin
						burst.zeros = 2'd1;
					end
				end else if (item.data_byte == BYTE_EPB && zero_run_q == 2'd2) begin
					burst.zeros = 2'd2;
					zero_run_n  = 2'd0;
				end else if (item.data_byte == BYTE_ONE && zero_run_q == 2'd2) begin
					zero_run_n    = 2'd0;
					burst.has_end = 1'b1;
					phase_n       = PH_DONE;
				end else begin
					burst.zeros    = zero_run_q;
					burst.has_byte = 1'b1;
					zero_run_n     = 2'd0;
				end
			end
			default: begin
			end
		endcase
		if (item.stream_last) begin
			if (phase_n == PH_INSIDE) begin
				burst.zeros   = burst.zeros + zero_run_n;
				burst.has_end = 1'b1;
			end
			phase_n    = PH_SEARCH;
			zero_run_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEARCH;
			zero_run_q <= 2'd0;
		end else if (accept) begin
			phase_q    <= phase_n;
			zero_run_q <= zero_run_n;
		end
	end

endmodule

FILE: sv/nalx_emit.sv
`timescale 1ns / 1ps

module nalx_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  nalx_pkg::burst_t  burst,
	output logic              res_valid,
	input  logic              res_stall,
	output nalx_pkg::result_t res
);
	import nalx_pkg::*;

	burst_t     burst_q;
	result_t    res_q;
	result_t    head;
	logic       res_valid_q;
	logic       pending;
	logic       single;
	logic       out_free;
	logic       accept;
	logic [2:0] count;

	assign count    = {1'b0, burst_q.zeros} + {2'b00, burst_q.has_byte}
		+ {2'b00, burst_q.has_end};
	assign pending  = count != 3'd0;
	assign single   = count == 3'd1;
	assign out_free = !res_valid_q || !res_stall;

	assign item_stall = pending && !(single && out_free);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		if (burst_q.zeros != 2'd0) begin
			head.out_byte   = BYTE_ZERO;
			head.byte_valid = 1'b1;
			head.nal_end    = 1'b0;
		end else if (burst_q.has_byte) begin
			head.out_byte   = burst_q.data;
			head.byte_valid = 1'b1;
			head.nal_end    = 1'b0;
		end else begin
			head.out_byte   = BYTE_ZERO;
			head.byte_valid = 1'b0;
			head.nal_end    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			burst_q     <= '0;
		end else begin
			if (out_free) begin
				res_valid_q <= pending;
			end
			if (accept) begin
				burst_q <= burst;
			end else if (out_free && pending) begin
				if (burst_q.zeros != 2'd0) begin
					burst_q.zeros <= burst_q.zeros - 2'd1;
				end else if (burst_q.has_byte) begin
					burst_q.has_byte <= 1'b0;
				end else begin
					burst_q.has_end <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pending) begin
			res_q <= head;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: sv/h264_nal_extract_epb_remove_core.sv
`timescale 1ns / 1ps

// Annex B NAL unit extractor with emulation prevention byte removal.
// item channel: one stream byte per transfer, stream_last on the final byte.
// res channel: payload bytes of the first NAL unit after a 00 00 01 start
// code, header byte first, with the 03 of each 00 00 03 dropped, then one
// end marker (byte_valid 0, nal_end 1) at the next start code or stream end.
// Zero bytes are held back until it is known they do not open an end code,
// so a byte may release up to four results (held zeros, itself, end marker).
// A byte's results wait in a burst register and leave via the result register.
// Throughput: one byte per cycle while each byte yields at most one result
// and res_stall is low; a byte yielding more holds item_stall until one
// is left, as the single result register drains one result per cycle unless stalled.
// A stalled result holds in the output register; item_stall rises as soon
// as buffered results cannot drain.
// Reset clears the search state and empties the output; no results are lost
// or invented across stalls.
module h264_nal_extract_epb_remove_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  nalx_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_stall,
	output nalx_pkg::result_t res
);
	import nalx_pkg::*;

	burst_t burst;
	logic   accept;

	assign accept = item_valid && !item_stall;

	nalx_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.burst  (burst)
	);

	nalx_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.burst      (burst),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule
